/* rtl/iaf_pkg.sv */
package iaf_pkg;

    // Operand widths.
    localparam int VALUE_BITS   = 32;
    localparam int POINTER_BITS = 64;

    // Digit counts for the widest value of each radix. The decimal count is
    // floor(bits * log10(2)) + 1, with log10(2) approximated as 1233 / 4096.
    localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int PTR_DIGITS = (POINTER_BITS + 3) / 4;

    localparam int MAX_A = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
    localparam int MAX_B = (HEX_DIGITS > PTR_DIGITS) ? HEX_DIGITS : PTR_DIGITS;
    localparam int NUM_DIGITS = (MAX_A > MAX_B) ? MAX_A : MAX_B;

    localparam int CNT_W    = $clog2(NUM_DIGITS + 1);
    localparam int BITCNT_W = $clog2(VALUE_BITS + 1);

    // Request kinds.
    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_OCT  = 3'd2;
    localparam logic [2:0] KIND_HEX  = 3'd3;
    localparam logic [2:0] KIND_PTR  = 3'd4;
    localparam logic [2:0] KIND_CHAR = 3'd5;

    // ASCII characters.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef logic [4*NUM_DIGITS-1:0] t_digits;
    typedef logic [CNT_W-1:0]        t_cnt;

    // Maps one digit to its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] letter_base;
        begin
            letter_base = upper ? CH_UPPER_A : CH_LOWER_A;
            if (d < 4'd10) begin
                digit_char = CH_ZERO + {4'b0000, d};
            end else begin
                digit_char = letter_base + {4'b0000, d} - 8'd10;
            end
        end
    endfunction

endpackage

/* rtl/iaf_bcd.sv */
module iaf_bcd (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [iaf_pkg::VALUE_BITS-1:0]         i_mag,
    output logic                                   o_done,
    output logic [4*iaf_pkg::DEC_DIGITS-1:0]       o_bcd
);

    // Bit-serial double dabble: one binary bit enters the BCD register per cycle.

    logic                                   r_busy, n_busy;
    logic                                   r_done, n_done;
    logic [iaf_pkg::BITCNT_W-1:0]           r_left, n_left;
    logic [iaf_pkg::VALUE_BITS-1:0]         r_bin, n_bin;
    logic [4*iaf_pkg::DEC_DIGITS-1:0]       r_bcd, n_bcd;
    logic [4*iaf_pkg::DEC_DIGITS-1:0]       adj;

    always_comb begin
        for (int j = 0; j < iaf_pkg::DEC_DIGITS; j++) begin
            if (r_bcd[4*j +: 4] >= 4'd5) begin
                adj[4*j +: 4] = r_bcd[4*j +: 4] + 4'd3;
            end else begin
                adj[4*j +: 4] = r_bcd[4*j +: 4];
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_left = r_left;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_left = iaf_pkg::BITCNT_W'(iaf_pkg::VALUE_BITS);
            n_bin  = i_mag;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bcd  = {adj[4*iaf_pkg::DEC_DIGITS-2:0], r_bin[iaf_pkg::VALUE_BITS-1]};
            n_bin  = r_bin << 1;
            n_left = r_left - 1'b1;
            if (r_left == iaf_pkg::BITCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// A character request goes straight to emission; octal, hex and pointer requests
// first drop leading zero digits, and decimal requests also wait first on the
// bit-serial binary-to-BCD conversion. Throughput: one request at a time, one
// character per cycle while the receiver does not stall, once the leading zero
// digits are dropped; a new request is taken while the last character waits.
// Sync active-low reset: idle, uppercase hex.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_value,
    // Character channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic        o_last_char,
    // Configuration write channel: hex_uppercase.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    // Engine states. CONV waits for the decimal converter, SKIP drops leading
    // zero digits one per cycle, EMIT sends the prefix and then the digits.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam int ND = iaf_pkg::NUM_DIGITS;

    logic [1:0]             r_state, n_state;
    logic                   r_hex_upper, n_hex_upper;
    logic                   r_upper, n_upper;
    logic [15:0]            r_pre, n_pre;
    logic [1:0]             r_pre_cnt, n_pre_cnt;
    iaf_pkg::t_digits       r_dig, n_dig;
    iaf_pkg::t_cnt          r_dig_cnt, n_dig_cnt;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    logic                                   in_acc;
    logic                                   can_push;
    logic [iaf_pkg::VALUE_BITS-1:0]         val;
    logic                                   neg;
    logic [iaf_pkg::VALUE_BITS-1:0]         mag;
    logic                                   bcd_start;
    logic                                   bcd_done;
    logic [4*iaf_pkg::DEC_DIGITS-1:0]       bcd;
    logic [3*iaf_pkg::OCT_DIGITS-1:0]       val_oct;
    iaf_pkg::t_digits                       oct_top, hex_top, ptr_top, dec_top;
    logic [3:0]                             top_digit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign can_push    = !r_out_valid || !i_out_stall;

    // Signed decimal prints the magnitude; the subtraction is taken modulo
    // 2^VALUE_BITS so the most negative value comes out as itself, unsigned.
    assign val = i_value[iaf_pkg::VALUE_BITS-1:0];
    assign neg = (i_kind == iaf_pkg::KIND_SDEC) && val[iaf_pkg::VALUE_BITS-1];
    assign mag = neg ? (iaf_pkg::VALUE_BITS'(0) - val) : val;
    assign bcd_start = in_acc &&
                       ((i_kind == iaf_pkg::KIND_SDEC) || (i_kind == iaf_pkg::KIND_UDEC));

    iaf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_mag   (mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    // Digit strings are loaded top-aligned in the digit shift register, so the
    // most significant digit always sits in the top nibble.
    assign val_oct = (3*iaf_pkg::OCT_DIGITS)'(val);

    always_comb begin
        oct_top = '0;
        for (int j = 0; j < iaf_pkg::OCT_DIGITS; j++) begin
            oct_top[4*(ND-iaf_pkg::OCT_DIGITS+j) +: 4] = {1'b0, val_oct[3*j +: 3]};
        end
        hex_top = '0;
        hex_top[4*ND-1 -: 4*iaf_pkg::HEX_DIGITS] = (4*iaf_pkg::HEX_DIGITS)'(val);
        ptr_top = '0;
        ptr_top[4*ND-1 -: 4*iaf_pkg::PTR_DIGITS] =
            (4*iaf_pkg::PTR_DIGITS)'(i_value[iaf_pkg::POINTER_BITS-1:0]);
        dec_top = '0;
        dec_top[4*ND-1 -: 4*iaf_pkg::DEC_DIGITS] = bcd;
    end

    assign top_digit = r_dig[4*ND-1 -: 4];

    always_comb begin
        n_state     = r_state;
        n_hex_upper = r_hex_upper;
        n_upper     = r_upper;
        n_pre       = r_pre;
        n_pre_cnt   = r_pre_cnt;
        n_dig       = r_dig;
        n_dig_cnt   = r_dig_cnt;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (i_cfg_valid) begin
            n_hex_upper = i_cfg_data;
        end

        // A word leaves the output register when the receiver does not stall.
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_upper   = 1'b0;
                    n_pre_cnt = 2'd0;
                    case (i_kind)
                        iaf_pkg::KIND_SDEC: begin
                            n_pre     = {iaf_pkg::CH_MINUS, 8'h00};
                            n_pre_cnt = neg ? 2'd1 : 2'd0;
                            n_state   = S_CONV;
                        end
                        iaf_pkg::KIND_UDEC: begin
                            n_state = S_CONV;
                        end
                        iaf_pkg::KIND_OCT: begin
                            n_dig     = oct_top;
                            n_dig_cnt = iaf_pkg::CNT_W'(iaf_pkg::OCT_DIGITS);
                            n_state   = S_SKIP;
                        end
                        iaf_pkg::KIND_HEX: begin
                            n_dig     = hex_top;
                            n_dig_cnt = iaf_pkg::CNT_W'(iaf_pkg::HEX_DIGITS);
                            n_upper   = r_hex_upper;
                            n_state   = S_SKIP;
                        end
                        iaf_pkg::KIND_PTR: begin
                            n_pre     = {iaf_pkg::CH_ZERO, iaf_pkg::CH_X};
                            n_pre_cnt = 2'd2;
                            n_dig     = ptr_top;
                            n_dig_cnt = iaf_pkg::CNT_W'(iaf_pkg::PTR_DIGITS);
                            n_state   = S_SKIP;
                        end
                        iaf_pkg::KIND_CHAR: begin
                            n_pre     = {i_value[7:0], 8'h00};
                            n_pre_cnt = 2'd1;
                            n_dig_cnt = '0;
                            n_state   = S_EMIT;
                        end
                        default: begin
                            // Undefined kinds are dropped without a result.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (bcd_done) begin
                    n_dig     = dec_top;
                    n_dig_cnt = iaf_pkg::CNT_W'(iaf_pkg::DEC_DIGITS);
                    n_state   = S_SKIP;
                end
            end
            S_SKIP: begin
                // Zero itself keeps its last digit.
                if ((top_digit == 4'd0) && (r_dig_cnt > iaf_pkg::CNT_W'(1))) begin
                    n_dig     = r_dig << 4;
                    n_dig_cnt = r_dig_cnt - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_push) begin
                    n_out_valid = 1'b1;
                    if (r_pre_cnt != 2'd0) begin
                        n_out_char = r_pre[15:8];
                        n_out_last = (r_pre_cnt == 2'd1) && (r_dig_cnt == '0);
                        n_pre      = r_pre << 8;
                        n_pre_cnt  = r_pre_cnt - 2'd1;
                    end else begin
                        n_out_char = iaf_pkg::digit_char(top_digit, r_upper);
                        n_out_last = (r_dig_cnt == iaf_pkg::CNT_W'(1));
                        n_dig      = r_dig << 4;
                        n_dig_cnt  = r_dig_cnt - 1'b1;
                    end
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hex_upper <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hex_upper <= n_hex_upper;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upper    <= n_upper;
        r_pre      <= n_pre;
        r_pre_cnt  <= n_pre_cnt;
        r_dig      <= n_dig;
        r_dig_cnt  <= n_dig_cnt;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

/* rtl/iaf_checker.sv */
module iaf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_kind,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_char,
    input logic        o_last_char
);

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word present after reset");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_char) && $stable(o_last_char))
        else $error("stalled output word changed");

    // An accepted request of a defined kind leaves the engine busy right after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind <= iaf_pkg::KIND_CHAR) |=> o_in_stall)
        else $error("engine free right after a valid request");

    // An undefined kind is dropped and leaves the engine free.
    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind > iaf_pkg::KIND_CHAR) |=> !o_in_stall)
        else $error("undefined kind occupied the engine");

endmodule

bind integer_to_ascii_formatter iaf_checker u_iaf_checker (.*);

/* dv/integer_to_ascii_formatter_tb.sv */
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
    import iaf_pkg::*;

    // Kinds 6 and 7 have no meaning. The block drops such a request and emits nothing.
    localparam logic [2:0] KIND_RSVD_LO = 3'd6;
    localparam logic [2:0] KIND_RSVD_HI = 3'd7;

    localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] POINTER_MASK = {64{1'b1}} >> (64 - POINTER_BITS);

    // A decimal request waits on the conversion and then on the skipping of leading
    // zero digits. DRAIN_CYCLES is the quiet time allowed after the last character
    // before the case register is touched, and again at the end.
    localparam int DRAIN_CYCLES = 2 * (VALUE_BITS + NUM_DIGITS) + 20;

    // The slowest correct run has about 375 requests. Each gives at most 18
    // characters, and each character may wait out the longest receiver stall.
    // The limit is several times what that adds up to.
    localparam int TIMEOUT_CYCLES = 1_500_000;

    // Long receiver holds start when the accepted request count hits these marks.
    localparam int HOLD_AT_FIRST  = 60;
    localparam int HOLD_AT_SECOND = 200;
    localparam int HOLD_CYCLES    = 400;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
    } request_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_word_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  req_kind  = '0;
    logic [63:0] req_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_char;
    logic        out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    integer_to_ascii_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_kind      (req_kind),
        .i_value     (req_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_char  (out_char),
        .o_last_char (out_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Requests that wait for the driver, and characters that the formatter still owes.
    request_t   pending_requests[$];
    char_word_t expected_chars[$];

    // This is the copy of the case register that the prediction uses. It changes
    // only while the block is idle.
    logic case_upper = 1'b1;

    // When set, neither side inserts gaps. Phases with back-to-back traffic use it.
    logic burst_mode = 1'b0;

    int requests_accepted = 0;
    int chars_checked     = 0;
    int mismatches        = 0;
    int case_writes       = 0;
    int holds_done        = 0;
    int hold_left         = 0;
    int kind_counts[8];

    // The gap length before the next word, or the stall run length. Most gaps
    // are zero or short. A few are long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Formats one request the way the block should. The characters are queued
    // most significant first, and the last one is flagged.
    function automatic void format_value(input logic [2:0] kind, input logic [63:0] value);
        logic [63:0]  magnitude;
        logic [7:0]   text[$];
        int unsigned  radix;
        logic         upper;
        logic [3:0]   digit;
        logic [7:0]   digits[$];
        char_word_t   word;
        radix     = 0;
        upper     = 1'b0;
        magnitude = value & VALUE_MASK;
        kind_counts[kind]++;
        case (kind)
            KIND_SDEC: begin
                radix = 10;
                // The magnitude is taken unsigned, so the most negative value survives.
                if (magnitude[VALUE_BITS-1]) begin
                    text.push_back(CH_MINUS);
                    magnitude = (~magnitude + 64'd1) & VALUE_MASK;
                end
            end
            KIND_UDEC: radix = 10;
            KIND_OCT:  radix = 8;
            KIND_HEX: begin
                radix = 16;
                upper = case_upper;
            end
            KIND_PTR: begin
                // Pointers are always lowercase. They carry the full pointer width.
                radix = 16;
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
                magnitude = value & POINTER_MASK;
            end
            KIND_CHAR: text.push_back(value[7:0]);
            default: ;
        endcase
        if (radix != 0) begin
            do begin
                digit = 4'(magnitude % radix);
                if (digit < 4'd10)
                    digits.push_front(CH_ZERO + 8'(digit));
                else
                    digits.push_front((upper ? CH_UPPER_A : CH_LOWER_A) + 8'(digit) - 8'd10);
                magnitude = magnitude / radix;
            end while (magnitude != 0);
            foreach (digits[i])
                text.push_back(digits[i]);
        end
        foreach (text[i]) begin
            word.code = text[i];
            word.last = (i == text.size() - 1);
            expected_chars.push_back(word);
        end
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Request driver. A word stays on the bus until it is taken. Its prediction
    // is made at the edge that accepts it. The valid signal is assigned once per
    // edge, so back-to-back words never see a low-high glitch.
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin
        logic     next_valid;
        request_t item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = in_valid;
            if (in_valid && !in_stall) begin
                format_value(req_kind, req_value);
                requests_accepted <= requests_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pending_requests.size() != 0) begin
                    item = pending_requests.pop_front();
                    req_kind  <= item.kind;
                    req_value <= item.value;
                    next_valid = 1'b1;
                    send_gap = pick_gap();
                end
            end
            in_valid <= next_valid;
        end
    end

    // The long hold runs in its own process. While it lasts, the receiver
    // refuses every character. The sender keeps offering requests, so the
    // formatter backs up and has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && requests_accepted == HOLD_AT_FIRST) ||
                     (holds_done == 1 && requests_accepted == HOLD_AT_SECOND)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Character monitor and receiver stall. The stall is drawn without regard
    // to valid, so it can land on any phase of the block's work.
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        logic       next_stall;
        char_word_t want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    flag_error($sformatf("unexpected character 0x%02h last=%0b",
                                         out_char, out_last));
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (out_char !== want.code || out_last !== want.last)
                        flag_error($sformatf(
                            "character %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                            chars_checked, want.code, want.last, out_char, out_last));
                end
            end
            if (hold_left != 0) begin
                next_stall = 1'b1;
            end else if (stall_left != 0) begin
                next_stall = 1'b1;
                stall_left--;
            end else begin
                next_stall = 1'b0;
                stall_left = pick_gap();
            end
            out_stall <= next_stall;
        end
    end

    task automatic add_request(input logic [2:0] kind, input logic [63:0] value);
        request_t item;
        item.kind  = kind;
        item.value = value;
        pending_requests.push_back(item);
    endtask

    // Returns operands that reach every digit count and both ends of the signed
    // range. Random upper bits check that only the used width matters.
    function automatic logic [63:0] random_operand();
        logic [63:0] raw;
        int unsigned roll;
        int unsigned width;
        raw   = {$urandom, $urandom};
        roll  = $urandom_range(0, 9);
        width = $urandom_range(1, 64);
        case (roll)
            0, 1, 2, 3: return raw & ({64{1'b1}} >> (64 - width));
            4, 5:       return raw;
            6:          return {raw[63:32], 32'($urandom_range(0, 20))};
            7:          return {raw[63:32], 32'h8000_0000 + 32'($urandom_range(0, 3))};
            8:          return {raw[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
            default:    return ($urandom_range(0, 1) != 0) ? {64{1'b1}} : 64'd0;
        endcase
    endfunction

    // Queues n meaningful requests. Some reserved kinds are mixed in. They do
    // not count toward n.
    task automatic add_random_requests(input int n);
        int          queued;
        logic [2:0]  kind;
        queued = 0;
        while (queued < n) begin
            if ($urandom_range(0, 99) < 3) begin
                kind = ($urandom_range(0, 1) != 0) ? KIND_RSVD_HI : KIND_RSVD_LO;
            end else begin
                kind = 3'($urandom_range(KIND_SDEC, KIND_CHAR));
                queued++;
            end
            add_request(kind, random_operand());
        end
    endtask

    // Waits until all queued words are taken and every predicted character has
    // arrived. The check runs on the falling edge, when everything the driver
    // did at the rising edge has settled. Then it waits out the tail, because a
    // reserved request may still be in flight.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_chars.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_hex_case(input logic upper);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= upper;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case_upper = upper;
        case_writes++;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with lowercase hex. It covers the zero and all-ones
        // ends of each kind, and the signed extremes with the most negative
        // value among them. Upper operand bits are set on several numeric
        // requests. The reserved kinds come just before one last character request.
        set_hex_case(1'b0);
        add_request(KIND_SDEC, 64'd0);
        add_request(KIND_SDEC, 64'hFFFF_FFFF_0000_0001);
        add_request(KIND_SDEC, 64'h0000_0000_FFFF_FFFF);
        add_request(KIND_SDEC, 64'h1234_5678_8000_0000);
        add_request(KIND_SDEC, 64'h0000_0000_7FFF_FFFF);
        add_request(KIND_UDEC, 64'd0);
        add_request(KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_UDEC, 64'h0000_0000_8000_0000);
        add_request(KIND_OCT,  64'd0);
        add_request(KIND_OCT,  64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_OCT,  64'd8);
        add_request(KIND_HEX,  64'd0);
        add_request(KIND_HEX,  64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_HEX,  64'h0000_0000_ABCD_EF01);
        add_request(KIND_PTR,  64'd0);
        add_request(KIND_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_PTR,  64'h0000_0001_DEAD_BEEF);
        add_request(KIND_CHAR, 64'd0);
        add_request(KIND_CHAR, 64'hFF);
        add_request(KIND_CHAR, 64'hFFFF_FFFF_FFFF_FF41);
        add_request(KIND_RSVD_LO, 64'h0000_0000_0000_0042);
        add_request(KIND_RSVD_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_CHAR, 64'h7A);
        wait_idle();

        // Random traffic with uppercase hex. The first long hold falls here.
        set_hex_case(1'b1);
        add_random_requests(120);
        wait_idle();

        // Lowercase again. The second hold falls in this phase.
        set_hex_case(1'b0);
        add_random_requests(120);
        wait_idle();

        // Uppercase with no gaps on either side, then with gaps again.
        set_hex_case(1'b1);
        burst_mode = 1'b1;
        add_random_requests(60);
        wait_idle();
        burst_mode = 1'b0;
        add_random_requests(50);
        wait_idle();

        $display({"Covered %0d requests (sdec %0d, udec %0d, oct %0d, hex %0d, ",
                  "ptr %0d, char %0d, reserved %0d),"},
                 requests_accepted, kind_counts[KIND_SDEC], kind_counts[KIND_UDEC],
                 kind_counts[KIND_OCT], kind_counts[KIND_HEX], kind_counts[KIND_PTR],
                 kind_counts[KIND_CHAR], kind_counts[KIND_RSVD_LO] + kind_counts[KIND_RSVD_HI]);
        $display({"%0d characters compared, %0d case register writes, ",
                  "%0d long output holds, %0d mismatches."},
                 chars_checked, case_writes, holds_done, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("integer_to_ascii_formatter test passed");
        else
            $display("integer_to_ascii_formatter test failed");
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Timeout: %0d characters still expected.", expected_chars.size());
        $display("integer_to_ascii_formatter test failed");
        $finish;
    end

endmodule
